/* design/mkd_pkg.sv */
package mkd_pkg;

  localparam int MAX_ENTRIES_DEF = 512;
  localparam int FIELD_W         = 16;
  localparam int SLOT_W          = 5;
  localparam int INDEX_W         = 9;
  localparam int GROUP_W         = 4 * FIELD_W;

  localparam logic MODE_CLEAR  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic [GROUP_W-1:0] shade;
    logic [GROUP_W-1:0] occl;
    logic [SLOT_W-1:0]  slot;
  } key_t;

endpackage

/* design/mkd_if.sv */
interface mkd_in_if import mkd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [FIELD_W-1:0] rotation;
  logic [FIELD_W-1:0] hue;
  logic [FIELD_W-1:0] saturation;
  logic [FIELD_W-1:0] brightness;
  logic [FIELD_W-1:0] occlusion_distance;
  logic [FIELD_W-1:0] cavity_factor;
  logic [FIELD_W-1:0] edge_factor;
  logic [FIELD_W-1:0] attenuation;
  logic [SLOT_W-1:0]  matcap_slot;

  modport source (
    output valid, mode, rotation, hue, saturation, brightness,
           occlusion_distance, cavity_factor, edge_factor, attenuation, matcap_slot,
    input  ready
  );
  modport sink (
    input  valid, mode, rotation, hue, saturation, brightness,
           occlusion_distance, cavity_factor, edge_factor, attenuation, matcap_slot,
    output ready
  );
endinterface

interface mkd_out_if import mkd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] entry_index;
  logic               was_added;
  logic               table_full;

  modport source (
    output valid, entry_index, was_added, table_full,
    input  ready
  );
  modport sink (
    input  valid, entry_index, was_added, table_full,
    output ready
  );
endinterface

/* design/mkd_key_mem.sv */
module mkd_key_mem import mkd_pkg::*; #(
  parameter int DEPTH  = MAX_ENTRIES_DEF,
  parameter int ADDR_W = $clog2(MAX_ENTRIES_DEF)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output key_t              rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  key_t              wr_data
);

  key_t mem [DEPTH];
  key_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/material_key_dedup_table.sv */
// Material key interning table.
// in_chan (valid/ready) carries one transaction per item: mode 0 clears the
// table, mode 1 looks up the key (eight 16-bit parameters plus matcap slot).
// out_chan (valid/ready) returns exactly one transaction per item: the index
// of the first stored entry equal to the key, or the index where the key was
// appended (was_added), or table_full with index 0 when no room is left.
// A clear, and a lookup on an empty table, load the result register straight
// from the idle state; any other lookup scans the stored entries from entry 0
// and stops at the first match or, after the last entry, appends or is full.
// The key store is one single-port-read memory scanned one entry per cycle,
// so scan time grows with table fill; items are handled one at a time.
// in_chan.ready is high when no lookup is in progress and the result
// register is empty or being drained. A stalled receiver holds the result
// and thereby holds off the next input transaction.
// Synchronous active-low reset empties the table and drops any pending
// result; the key memory contents are not cleared.
module material_key_dedup_table import mkd_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input logic clk,
  input logic rst_n,
  mkd_in_if.sink    in_chan,
  mkd_out_if.source out_chan
);

  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int EXT_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] cmp_idx_r, cmp_idx_nxt;
  key_t              key_r, key_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0] index_r;
  logic               added_r;
  logic               full_r;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  key_t              rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  key_t              wr_data;

  logic              res_load;
  logic [ADDR_W-1:0] res_idx;
  logic              res_added;
  logic              res_full;
  logic [EXT_W-1:0]  res_idx_ext;

  logic in_acc;
  logic last_entry;
  key_t in_key;

  assign in_chan.ready = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign in_key.shade = {in_chan.brightness, in_chan.saturation, in_chan.hue,
                         in_chan.rotation};
  assign in_key.occl  = {in_chan.attenuation, in_chan.edge_factor,
                         in_chan.cavity_factor, in_chan.occlusion_distance};
  assign in_key.slot  = in_chan.matcap_slot;

  assign last_entry = (CNT_W'(cmp_idx_r) == (count_r - CNT_W'(1)));

  mkd_key_mem #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_key_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    cmp_idx_nxt = cmp_idx_r;
    key_nxt     = key_r;
    rd_en       = 1'b0;
    rd_addr     = ADDR_W'(cmp_idx_r + 1'b1);
    wr_en       = 1'b0;
    wr_addr     = count_r[ADDR_W-1:0];
    wr_data     = key_r;
    res_load    = 1'b0;
    res_idx     = '0;
    res_added   = 1'b0;
    res_full    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.mode == MODE_CLEAR) begin
            count_nxt = '0;
            res_load  = 1'b1;
          end else begin
            key_nxt = in_key;
            if (count_r == '0) begin
              // empty table: append at once, nothing to scan
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_data   = in_key;
              count_nxt = CNT_W'(1);
              res_load  = 1'b1;
              res_added = 1'b1;
            end else begin
              rd_en       = 1'b1;
              rd_addr     = '0;
              cmp_idx_nxt = '0;
              state_nxt   = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (rd_data == key_r) begin
          res_load  = 1'b1;
          res_idx   = cmp_idx_r;
          state_nxt = ST_IDLE;
        end else if (last_entry) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (count_r != CNT_W'(MAX_ENTRIES)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            res_idx   = count_r[ADDR_W-1:0];
            res_added = 1'b1;
          end else begin
            res_full = 1'b1;
          end
        end else begin
          rd_en       = 1'b1;
          cmp_idx_nxt = ADDR_W'(cmp_idx_r + 1'b1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_idx_ext   = EXT_W'(res_idx);
  assign out_valid_nxt = res_load ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    key_r     <= key_nxt;
    if (res_load) begin
      index_r <= res_idx_ext[INDEX_W-1:0];
      added_r <= res_added;
      full_r  <= res_full;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.entry_index = index_r;
  assign out_chan.was_added   = added_r;
  assign out_chan.table_full  = full_r;

endmodule

/* design/mkd_checker.sv */
module mkd_checker import mkd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_mode,
  input logic               out_valid,
  input logic               out_ready,
  input logic [INDEX_W-1:0] entry_index,
  input logic               was_added,
  input logic               table_full
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(was_added && table_full))
    else $error("added and full both set");

  a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && table_full |-> entry_index == '0)
    else $error("full result with nonzero index");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_CLEAR |=>
      out_valid && entry_index == '0 && !was_added && !table_full)
    else $error("clear did not return its result next cycle");

endmodule

bind material_key_dedup_table mkd_checker u_mkd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_mode     (in_chan.mode),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .entry_index (out_chan.entry_index),
  .was_added   (out_chan.was_added),
  .table_full  (out_chan.table_full)
);
